// ===== design/rmst_pkg.sv =====
// ----------------------------------------------------------------------------
// rmst_pkg: shared types and constants of the mapping slot table
// Status codes, opcodes, register indexes and the front-to-back command.
// ----------------------------------------------------------------------------
package rmst_pkg;

  localparam int ADDR_W = 32;
  localparam int PAGE_W = 20;
  localparam int OFF_W = 12;
  localparam int STATUS_W = 3;
  localparam int SLOT_OUT_W = 10;
  localparam int REG_IDX_W = 2;

  typedef enum logic [0:0] {
    OP_MAP = 1'b0,
    OP_UNMAP = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DIRECT = 3'd0,
    ST_REUSED = 3'd1,
    ST_NEW = 3'd2,
    ST_FULL = 3'd3,
    ST_KEPT = 3'd4,
    ST_FREED = 3'd5,
    ST_IGNORED = 3'd6
  } status_t;

  localparam logic [REG_IDX_W-1:0] REG_DIRECT_LIMIT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_DIRECT_OFFSET = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_BASE = 2'd2;

  localparam logic [ADDR_W-1:0] RST_DIRECT_LIMIT = 32'h0040_0000;
  localparam logic [ADDR_W-1:0] RST_DIRECT_OFFSET = 32'hC000_0000;
  localparam logic [ADDR_W-1:0] RST_WINDOW_BASE = 32'hF000_0000;

  // Command kinds handed from front to back
  typedef enum logic [1:0] {
    CMD_DONE = 2'd0,   // result already final (direct, ignored)
    CMD_MAP = 2'd1,    // table search needed
    CMD_UNMAP = 2'd2   // slot decrement needed
  } cmd_kind_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CLEAR,
    BK_SCAN,
    BK_UNRD,
    BK_UNWR,
    BK_WRITE,
    BK_OUT
  } bk_state_t;

endpackage

// ===== design/rmst_if.sv =====
// ----------------------------------------------------------------------------
// rmst_req_if / rmst_rsp_if / rmst_cfg_if: valid-ready channels
// Payload of requests, results and register writes.
// ----------------------------------------------------------------------------
interface rmst_req_if;
  logic valid;
  logic ready;
  logic op;
  logic [31:0] paddr;
  logic [31:0] virt_addr;
  modport source(output valid, op, paddr, virt_addr, input ready);
  modport sink(input valid, op, paddr, virt_addr, output ready);
endinterface

interface rmst_rsp_if;
  logic valid;
  logic ready;
  logic [31:0] result_addr;
  logic [2:0] status;
  logic [9:0] slot_index;
  modport source(output valid, result_addr, status, slot_index, input ready);
  modport sink(input valid, result_addr, status, slot_index, output ready);
endinterface

interface rmst_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== design/rmst_front.sv =====
// ----------------------------------------------------------------------------
// rmst_front: request classifier
// Splits requests into finished direct/ignored results and table commands,
// pushes them into a two-entry queue toward the back end.
// ----------------------------------------------------------------------------
module rmst_front #(
  parameter int SLOTS = 1024
) (
  input  logic clk,
  input  logic rst,
  rmst_req_if.sink req,
  input  logic [rmst_pkg::ADDR_W-1:0] direct_limit,
  input  logic [rmst_pkg::ADDR_W-1:0] direct_offset,
  input  logic [rmst_pkg::ADDR_W-1:0] window_base,
  input  logic pop,
  output logic q_valid,
  output rmst_pkg::cmd_kind_t q_kind,
  output logic [rmst_pkg::ADDR_W-1:0] q_addr,
  output logic [rmst_pkg::PAGE_W-1:0] q_page,
  output logic [$clog2(SLOTS)-1:0] q_slot,
  output logic q_unmap
);
  import rmst_pkg::*;
  localparam int SW = $clog2(SLOTS);

  cmd_kind_t kind_q [2];
  logic [ADDR_W-1:0] addr_q [2];
  logic [PAGE_W-1:0] page_q [2];
  logic [SW-1:0] slot_q [2];
  logic unmap_q [2];
  logic wptr, rptr;
  logic [1:0] count;

  cmd_kind_t c_kind;
  logic [ADDR_W-1:0] c_addr;
  logic [32:0] va_off;
  logic [SW-1:0] c_slot;
  logic in_win;
  logic push;

  // Offset into the window, 33 bits so that wrap shows as out of range
  always_comb begin
    va_off = {1'b0, req.virt_addr} - {1'b0, window_base};
    in_win = !va_off[32] && (va_off[31:OFF_W] < 20'(SLOTS));
    c_slot = va_off[OFF_W +: SW];
    c_addr = '0;
    if (req.op == OP_MAP) begin
      if ({req.paddr[31:OFF_W], {OFF_W{1'b0}}} < direct_limit) begin
        c_kind = CMD_DONE;
        c_addr = req.paddr + direct_offset;
      end else begin
        c_kind = CMD_MAP;
      end
    end else if (in_win) begin
      c_kind = CMD_UNMAP;
    end else begin
      c_kind = CMD_DONE;
    end
  end

  assign req.ready = (count != 2'd2);
  assign push = req.valid && req.ready;
  assign q_valid = (count != 2'd0);
  assign q_kind = kind_q[rptr];
  assign q_addr = addr_q[rptr];
  assign q_page = page_q[rptr];
  assign q_slot = slot_q[rptr];
  assign q_unmap = unmap_q[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
    if (push) begin
      kind_q[wptr] <= c_kind;
      addr_q[wptr] <= c_addr;
      page_q[wptr] <= req.paddr[31:OFF_W];
      slot_q[wptr] <= c_slot;
      unmap_q[wptr] <= (req.op == OP_UNMAP);
    end
  end

  // A direct map carries its final address; status follows from op
  assert property (@(posedge clk) disable iff (rst) pop |-> q_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue overfilled");
  assert property (@(posedge clk) disable iff (rst)
      push && !pop |=> count == $past(count) + 2'd1)
    else $error("queue count slip");
endmodule

// ===== design/rmst_back.sv =====
// ----------------------------------------------------------------------------
// rmst_back: slot table engine
// Holds the slot memory, clears it after reset, scans for matches and free
// slots one entry per cycle and performs unmap decrements.
// ----------------------------------------------------------------------------
module rmst_back #(
  parameter int SLOTS = 1024,
  parameter int REF_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  rmst_pkg::cmd_kind_t q_kind,
  input  logic [rmst_pkg::ADDR_W-1:0] q_addr,
  input  logic [rmst_pkg::PAGE_W-1:0] q_page,
  input  logic [$clog2(SLOTS)-1:0] q_slot,
  input  logic q_op_unmap,
  input  logic [rmst_pkg::ADDR_W-1:0] window_base,
  output logic pop,
  rmst_rsp_if.source rsp
);
  import rmst_pkg::*;
  localparam int SW = $clog2(SLOTS);
  localparam logic [REF_BITS-1:0] REF_MAX = '1;

  logic [PAGE_W+REF_BITS-1:0] mem [SLOTS];
  logic [PAGE_W+REF_BITS-1:0] rd;
  logic [SW-1:0] rd_addr;
  logic we;
  logic [SW-1:0] wr_addr;
  logic [PAGE_W+REF_BITS-1:0] wr_data;

  bk_state_t state, state_next;
  logic [SW:0] idx;          // scan and clear position
  logic [SW-1:0] cur;        // index of data in rd
  logic rd_live;             // rd holds a valid read
  logic have_free;
  logic [SW-1:0] free_idx;
  logic [SW-1:0] hit_idx;
  logic [REF_BITS-1:0] hit_refs;
  logic [ADDR_W-1:0] o_addr;
  status_t o_status;
  logic [SW-1:0] o_slot;

  logic [PAGE_W-1:0] rd_page;
  logic [REF_BITS-1:0] rd_refs;
  logic match, last;

  assign rd_page = rd[REF_BITS +: PAGE_W];
  assign rd_refs = rd[REF_BITS-1:0];
  assign match = rd_live && (rd_refs != '0) && (rd_page == q_page);
  assign last = rd_live && (cur == SW'(SLOTS - 1));

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
    rd <= mem[rd_addr];
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_CLEAR: if (idx == (SW+1)'(SLOTS - 1)) state_next = BK_IDLE;
      BK_IDLE: begin
        if (q_valid) begin
          unique case (q_kind)
            CMD_MAP: state_next = BK_SCAN;
            CMD_UNMAP: state_next = BK_UNRD;
            default: state_next = BK_OUT;
          endcase
        end
      end
      BK_SCAN: if (match || last) state_next = BK_WRITE;
      BK_UNRD: state_next = BK_UNWR;
      BK_UNWR: state_next = BK_OUT;
      BK_WRITE: state_next = BK_OUT;
      BK_OUT: if (rsp.ready) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  // Memory controls and output
  always_comb begin
    we = 1'b0;
    wr_addr = hit_idx;
    wr_data = '0;
    rd_addr = idx[SW-1:0];
    unique case (state)
      BK_CLEAR: begin
        we = 1'b1;
        wr_addr = idx[SW-1:0];
      end
      // a scan starts at slot 0, an unmap reads its own slot
      BK_IDLE: rd_addr = (q_kind == CMD_MAP) ? '0 : q_slot;
      BK_UNRD: rd_addr = q_slot;
      BK_UNWR: begin
        we = (rd_refs != '0);
        wr_addr = q_slot;
        wr_data = (rd_refs == REF_BITS'(1)) ? '0 : {rd_page, rd_refs - REF_BITS'(1)};
      end
      BK_WRITE: begin
        we = 1'b1;
        if (o_status == ST_REUSED) begin
          wr_addr = hit_idx;
          wr_data = {q_page, (hit_refs == REF_MAX) ? hit_refs : hit_refs + REF_BITS'(1)};
        end else begin
          we = (o_status == ST_NEW);
          wr_addr = free_idx;
          wr_data = {q_page, REF_BITS'(1)};
        end
      end
      default: ;
    endcase
  end

  assign pop = (state == BK_OUT) && rsp.ready;
  assign rsp.valid = (state == BK_OUT);
  assign rsp.result_addr = o_addr;
  assign rsp.status = o_status;
  assign rsp.slot_index = SLOT_OUT_W'(o_slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_CLEAR;
      idx <= '0;
      rd_live <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        BK_CLEAR: idx <= idx + 1'b1;
        BK_IDLE: begin
          idx <= (SW+1)'(1);
          rd_live <= 1'b0;
          cur <= '0;
          have_free <= 1'b0;
          free_idx <= '0;
          if (q_valid) begin
            rd_live <= (q_kind == CMD_MAP);
            o_addr <= q_addr;
            o_slot <= '0;
            o_status <= q_op_unmap ? ST_IGNORED : ST_DIRECT;
          end
        end
        BK_SCAN: begin
          cur <= idx[SW-1:0];
          idx <= idx + 1'b1;
          if (!have_free && rd_refs == '0) begin
            have_free <= 1'b1;
            free_idx <= cur;
          end
          if (match) begin
            hit_idx <= cur;
            hit_refs <= rd_refs;
            o_status <= ST_REUSED;
            o_slot <= cur;
            o_addr <= window_base + ADDR_W'({cur, {OFF_W{1'b0}}});
          end else if (last) begin
            if (have_free || rd_refs == '0) begin
              o_status <= ST_NEW;
              o_slot <= have_free ? free_idx : cur;
              o_addr <= window_base +
                        ADDR_W'({(have_free ? free_idx : cur), {OFF_W{1'b0}}});
              free_idx <= have_free ? free_idx : cur;
            end else begin
              o_status <= ST_FULL;
              o_addr <= '0;
            end
          end
        end
        BK_UNWR: begin
          o_addr <= '0;
          if (rd_refs == '0) begin
            o_status <= ST_IGNORED;
          end else begin
            o_slot <= q_slot;
            o_status <= (rd_refs == REF_BITS'(1)) ? ST_FREED : ST_KEPT;
          end
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) rsp.valid |-> q_valid)
    else $error("result without queued command");
  assert property (@(posedge clk) disable iff (rst)
      state == BK_WRITE && o_status == ST_FULL |-> !we)
    else $error("write on full pool");
  assert property (@(posedge clk) disable iff (rst)
      rsp.valid && (o_status == ST_KEPT || o_status == ST_FREED) |-> o_addr == '0)
    else $error("unmap with address");
endmodule

// ===== design/refcounted_map_slot_table_core.sv =====
// ----------------------------------------------------------------------------
// refcounted_map_slot_table_core: temporary mapping slot pool
// Map/unmap requests against a reference-counted table of page slots.
// ----------------------------------------------------------------------------
// After reset the slot memory is cleared; up to two requests are taken into the
// queue meanwhile and wait for the clear to finish. A direct map or an ignored
// unmap goes straight from IDLE to OUT, an in-window unmap reads its slot (UNRD)
// and writes it back (UNWR) before OUT, and a windowed map scans the slot memory
// one entry per cycle (SCAN), stopping at the first hit or after the last slot,
// then updates the chosen slot unless the pool is full (WRITE) and gives (OUT).
// A two-entry queue sits between the classifier and the table engine.
module refcounted_map_slot_table_core #(
  parameter int SLOTS = 1024,
  parameter int REF_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  rmst_req_if.sink req,
  rmst_rsp_if.source rsp,
  rmst_cfg_if.sink cfg
);
  import rmst_pkg::*;
  localparam int SW = $clog2(SLOTS);

  logic [ADDR_W-1:0] direct_limit, direct_offset, window_base;
  logic q_valid, pop;
  cmd_kind_t q_kind;
  logic [ADDR_W-1:0] q_addr;
  logic [PAGE_W-1:0] q_page;
  logic [SW-1:0] q_slot;
  logic q_unmap;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      direct_limit <= RST_DIRECT_LIMIT;
      direct_offset <= RST_DIRECT_OFFSET;
      window_base <= RST_WINDOW_BASE;
    end else if (cfg.valid) begin
      priority case (cfg.index)
        REG_DIRECT_LIMIT: direct_limit <= cfg.data;
        REG_DIRECT_OFFSET: direct_offset <= cfg.data;
        REG_WINDOW_BASE: window_base <= cfg.data;
        default: ;
      endcase
    end
  end

  rmst_front #(.SLOTS(SLOTS)) u_front (
    .clk, .rst, .req,
    .direct_limit, .direct_offset, .window_base,
    .pop, .q_valid, .q_kind, .q_addr, .q_page, .q_slot, .q_unmap
  );

  rmst_back #(.SLOTS(SLOTS), .REF_BITS(REF_BITS)) u_back (
    .clk, .rst, .q_valid, .q_kind, .q_addr, .q_page, .q_slot,
    .q_op_unmap(q_unmap),
    .window_base, .pop, .rsp
  );
endmodule

// ===== verif/refcounted_map_slot_table_core_tb.sv =====
// ----------------------------------------------------------------------------
// refcounted_map_slot_table_core_tb: self-checking bench for the slot table
// Drives map/unmap requests and register writes through valid-ready channels,
// predicts each result from a local slot table, and compares every result.
// ----------------------------------------------------------------------------
module refcounted_map_slot_table_core_tb;
  import rmst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 1024;
  localparam int REF_BITS = 16;
  localparam int WATCHDOG = 40000;
  localparam logic [REF_BITS-1:0] REF_MAX = '1;

  typedef struct packed {
    logic is_cfg;
    logic [1:0] idx;
    logic [31:0] data;
    op_t op;
    logic [31:0] pa;
    logic [31:0] va;
    logic drain;  // hold until every expected result has come
  } req_item_t;

  typedef struct packed {
    logic [31:0] addr;
    status_t status;
    logic [9:0] slot;
  } map_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rmst_req_if req();
  rmst_rsp_if rsp();
  rmst_cfg_if cfg();

  refcounted_map_slot_table_core #(.SLOTS(SLOTS), .REF_BITS(REF_BITS)) uut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
  );

  req_item_t pending[$];
  map_result_t expected_results[$];
  int errors = 0;
  int stall_left = 0;
  int gap_left = 0;
  int idle_cycles = 0;
  int quiet_wait = 0;
  bit calm = 0;
  bit stim_done = 0;

  // local copy of table and registers
  logic [31:0] lim_q, off_q, base_q;
  logic [19:0] page_q[SLOTS];
  logic [REF_BITS-1:0] refs_q[SLOTS];

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    errors++;
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
  endtask

  function automatic map_result_t predict_mapping(input req_item_t it);
    map_result_t r;
    logic [63:0] rel;
    int s;
    r = '{addr: 32'd0, status: ST_IGNORED, slot: 10'd0};
    if (it.op == OP_MAP) begin
      if ({it.pa[31:12], 12'd0} < lim_q) begin
        r.addr = it.pa + off_q;
        r.status = ST_DIRECT;
        return r;
      end
      for (s = 0; s < SLOTS; s++) begin
        if (refs_q[s] != 0 && page_q[s] == it.pa[31:12]) begin
          if (refs_q[s] != REF_MAX) refs_q[s]++;
          r.addr = base_q + 32'(s) * 32'd4096;
          r.status = ST_REUSED;
          r.slot = 10'(s);
          return r;
        end
      end
      for (s = 0; s < SLOTS; s++) begin
        if (refs_q[s] == 0) begin
          page_q[s] = it.pa[31:12];
          refs_q[s] = 1;
          r.addr = base_q + 32'(s) * 32'd4096;
          r.status = ST_NEW;
          r.slot = 10'(s);
          return r;
        end
      end
      r.status = ST_FULL;
      return r;
    end
    if (it.va < base_q) return r;
    rel = 64'(it.va) - 64'(base_q);
    if (rel >= 64'(SLOTS) * 4096) return r;
    s = int'(rel / 4096);
    if (refs_q[s] == 0) return r;
    refs_q[s]--;
    r.slot = 10'(s);
    if (refs_q[s] == 0) begin
      page_q[s] = '0;
      r.status = ST_FREED;
    end else begin
      r.status = ST_KEPT;
    end
    return r;
  endfunction

  function automatic req_item_t map_req(input logic [31:0] pa);
    req_item_t it;
    it = '0;
    it.op = OP_MAP;
    it.pa = pa;
    it.va = $urandom;
    return it;
  endfunction

  function automatic req_item_t unmap_req(input logic [31:0] va);
    req_item_t it;
    it = '0;
    it.op = OP_UNMAP;
    it.va = va;
    it.pa = $urandom;
    return it;
  endfunction

  function automatic req_item_t reg_write(input logic [1:0] idx, input logic [31:0] d);
    req_item_t it;
    it = '0;
    it.is_cfg = 1'b1;
    it.idx = idx;
    it.data = d;
    return it;
  endfunction

  function automatic bit predict_and_queue(input logic op, input logic [31:0] pa,
                                           input logic [31:0] va);
    req_item_t it;
    it = '0;
    it.op = op_t'(op);
    it.pa = pa;
    it.va = va;
    expected_results.push_back(predict_mapping(it));
    return 1'b1;
  endfunction

  // window-relative addresses use the base passed in, matching the writes queued before each phase
  task automatic random_phase(input int n, input logic [31:0] base, input logic [31:0] lim);
    int k;
    logic [31:0] pg;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(9))
        0: pending.push_back(map_req($urandom));
        1: pending.push_back(unmap_req($urandom));
        2, 3, 4: begin
          // small set of windowed pages so reuse happens
          pg = (lim >> 12) + $urandom_range(12);
          pending.push_back(map_req({pg[19:0], 12'(($urandom))}));
        end
        5: pending.push_back(map_req({20'($urandom_range(2)), 12'($urandom)}));
        default: pending.push_back(unmap_req(base + 32'($urandom_range(20)) * 4096
                                             + 32'($urandom_range(4095))));
      endcase
    end
  endtask

  initial begin
    req_item_t d;
    pending.push_back(map_req(32'h0000_0000));
    pending.push_back(map_req(32'h003F_FFFF));
    pending.push_back(map_req(32'h0040_0000));
    pending.push_back(map_req(32'h0040_0ABC));
    pending.push_back(map_req(32'hFFFF_FFFF));
    pending.push_back(unmap_req(32'hF000_0FFF));
    pending.push_back(unmap_req(32'hF000_0000));
    pending.push_back(unmap_req(32'hF000_1000));
    pending.push_back(unmap_req(32'hF000_1000));
    pending.push_back(unmap_req(32'hEFFF_FFFF));
    pending.push_back(unmap_req(32'hF040_0000));
    pending.push_back(unmap_req(32'hF03F_FFFF));
    pending.push_back(unmap_req(32'hF000_5000));
    random_phase(120, RST_WINDOW_BASE, RST_DIRECT_LIMIT);
    // unaligned window reaching the top of the address space
    d = reg_write(REG_DIRECT_LIMIT, 32'd0);
    d.drain = 1'b1;
    pending.push_back(d);
    pending.push_back(reg_write(REG_WINDOW_BASE, 32'hFFC0_0800));
    pending.push_back(reg_write(REG_DIRECT_OFFSET, 32'hFFFF_FFFF));
    pending.push_back(map_req(32'h1000_0000));
    pending.push_back(unmap_req(32'hFFFF_FFFF));
    pending.push_back(unmap_req(32'hFFC0_07FF));
    random_phase(100, 32'hFFC0_0800, 32'h1000_0000);
    // everything direct with a huge limit
    d = reg_write(REG_DIRECT_LIMIT, 32'hFFFF_FFFF);
    d.drain = 1'b1;
    pending.push_back(d);
    pending.push_back(reg_write(REG_DIRECT_OFFSET, 32'd0));
    pending.push_back(reg_write(REG_WINDOW_BASE, 32'd0));
    random_phase(60, 32'd0, 32'hFFFF_F000);
    pending.push_back(map_req(32'hFFFF_F123));
    d = reg_write(REG_DIRECT_LIMIT, 32'h0000_1000);
    d.drain = 1'b1;
    pending.push_back(d);
    random_phase(130, 32'd0, 32'h0000_1000);
    d = reg_write(REG_DIRECT_LIMIT, 32'h0002_0000);
    d.drain = 1'b1;
    pending.push_back(d);
    pending.push_back(reg_write(REG_DIRECT_OFFSET, $urandom));
    pending.push_back(reg_write(REG_WINDOW_BASE, 32'h8000_0000));
    d = map_req(32'h0003_0000);
    d.drain = 1'b1;
    pending.push_back(d);
    random_phase(130, 32'h8000_0000, 32'h0002_0000);
  end

  // driver: requests and register writes
  always @(posedge clk) begin
    req_item_t h;
    if (rst) begin
      req.valid <= 1'b0;
      cfg.valid <= 1'b0;
      req.op <= 1'b0;
      req.paddr <= '0;
      req.virt_addr <= '0;
      cfg.index <= '0;
      cfg.data <= '0;
      lim_q = RST_DIRECT_LIMIT;
      off_q = RST_DIRECT_OFFSET;
      base_q = RST_WINDOW_BASE;
      for (int s = 0; s < SLOTS; s++) begin
        page_q[s] = '0;
        refs_q[s] = '0;
      end
    end else begin
      if (req.valid && req.ready) void'(predict_and_queue(req.op, req.paddr, req.virt_addr));
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_DIRECT_LIMIT: lim_q = cfg.data;
          REG_DIRECT_OFFSET: off_q = cfg.data;
          REG_WINDOW_BASE: base_q = cfg.data;
          default: ;
        endcase
      end
      if ((req.valid && !req.ready) || (cfg.valid && !cfg.ready)) begin
        // hold current transfer
      end else if (pending.size() == 0) begin
        req.valid <= 1'b0;
        cfg.valid <= 1'b0;
        stim_done = 1'b1;
      end else if (pending[0].drain && (expected_results.size() != 0 || quiet_wait < 20)) begin
        req.valid <= 1'b0;
        cfg.valid <= 1'b0;
        quiet_wait = (expected_results.size() != 0) ? 0 : quiet_wait + 1;
      end else if (gap_left > 0) begin
        req.valid <= 1'b0;
        cfg.valid <= 1'b0;
        gap_left--;
      end else if (!calm && $urandom_range(5) == 0) begin
        req.valid <= 1'b0;
        cfg.valid <= 1'b0;
        gap_left = $urandom_range(3);
      end else begin
        h = pending.pop_front();
        quiet_wait = 0;
        if (pending.size() < 120) calm = 1'b1;
        req.valid <= !h.is_cfg;
        cfg.valid <= h.is_cfg;
        req.op <= h.op;
        req.paddr <= h.pa;
        req.virt_addr <= h.va;
        cfg.index <= h.idx;
        cfg.data <= h.data;
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    map_result_t e;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          report("unexpected result", rsp.result_addr, 32'd0);
        end else begin
          e = expected_results.pop_front();
          if (rsp.result_addr !== e.addr) report("result_addr", rsp.result_addr, e.addr);
          if (rsp.status !== e.status) report("status", 32'(rsp.status), 32'(e.status));
          if (rsp.slot_index !== e.slot) report("slot_index", 32'(rsp.slot_index), 32'(e.slot));
        end
      end
      if (stall_left > 0) begin
        rsp.ready <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(5) == 0) begin
        rsp.ready <= 1'b0;
        stall_left = $urandom_range(3);
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // watchdog counts cycles without any transfer
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
        $display("[refcounted_map_slot_table_core] ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    wait (stim_done && expected_results.size() == 0);
    repeat (SLOTS + 20) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("[refcounted_map_slot_table_core] OK");
    end else begin
      $display("[refcounted_map_slot_table_core] ERROR");
    end
    $finish;
  end
endmodule
